FILE: src/lkvc_pkg.sv
// Package: shared constants, request/response types and controller types for the LRU cache.
package lkvc_pkg;

  localparam int ENTRIES      = 16;
  localparam int KEY_BITS     = 32;
  localparam int DATA_BITS    = 32;
  localparam int CAP_BITS     = 5;
  localparam int SKEY_BITS    = (KEY_BITS < DATA_BITS) ? KEY_BITS : DATA_BITS;
  localparam int RANK_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_BITS     = $clog2(ENTRIES + 1);
  localparam int CMP_BITS     = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                        op;
    logic signed [DATA_BITS-1:0] key;
    logic signed [DATA_BITS-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                        hit;
    logic signed [DATA_BITS-1:0] read_value;
    logic                        evicted;
    logic signed [DATA_BITS-1:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
  } ctl_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

endpackage

FILE: src/lkvc_ctrl.sv
// Controller: sequences accept, lookup and update for each request.
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output lkvc_pkg::ctl_cmd_t cmd
);

  lkvc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = lkvc_pkg::ST_LOOKUP;
        end
      end
      lkvc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = lkvc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/lkvc_dp.sv
// Datapath: entry storage, parallel key match, LRU ranks and response register.
module lkvc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lkvc_pkg::ctl_cmd_t               cmd,
  input  lkvc_pkg::req_t                   in_req,
  input  logic                             cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0]    cfg_wdata,
  output logic                             out_valid,
  output lkvc_pkg::rsp_t                   out_rsp
);

  localparam int N  = lkvc_pkg::ENTRIES;
  localparam int KB = lkvc_pkg::SKEY_BITS;
  localparam int DB = lkvc_pkg::DATA_BITS;
  localparam int RB = lkvc_pkg::RANK_BITS;
  localparam int OB = lkvc_pkg::OCC_BITS;
  localparam int CB = lkvc_pkg::CMP_BITS;

  logic [N-1:0]                 valid_r, valid_nxt;
  logic [KB-1:0]                keys_r [N];
  logic [DB-1:0]                vals_r [N];
  logic [RB-1:0]                rank_r [N];
  logic [RB-1:0]                rank_nxt [N];
  logic [OB-1:0]                occ_r, occ_nxt;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_r;
  lkvc_pkg::req_t               req_r;

  logic [N-1:0]  hit_vec, vic_vec;
  logic [RB-1:0] hit_rank;
  logic [DB-1:0] hit_val;
  logic [KB-1:0] vic_key;
  logic [KB-1:0] req_key;
  logic [RB-1:0] occ_m1;
  logic [CB-1:0] cap_x, occ_x, eff_cap;
  logic          full;

  logic [N-1:0]  hit_vec_r, vic_vec_r;
  logic [RB-1:0] hit_rank_r;
  logic [DB-1:0] hit_val_r;
  logic [KB-1:0] vic_key_r;
  logic          full_r;

  logic [N-1:0]  after, free_vec, slot_vec, key_we, val_we;
  logic          hit, is_put, evict, found;
  lkvc_pkg::rsp_t rsp_nxt;
  lkvc_pkg::rsp_t rsp_r;
  logic          rsp_valid_r;

  assign req_key = req_r.key[KB-1:0];
  assign occ_m1  = RB'(occ_r - OB'(1));
  assign cap_x   = CB'(cap_r);
  assign occ_x   = CB'(occ_r);

  always_comb begin
    if (cap_x == '0) begin
      eff_cap = CB'(1);
    end else if (cap_x > CB'(N)) begin
      eff_cap = CB'(N);
    end else begin
      eff_cap = cap_x;
    end
    full = (occ_x >= eff_cap);
  end

  // parallel match; ranks of valid entries are distinct, so the LRU entry is rank occ-1
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    vic_key  = '0;
    for (int i = 0; i < N; i++) begin
      hit_vec[i] = valid_r[i] && (keys_r[i] == req_key);
      vic_vec[i] = valid_r[i] && (rank_r[i] == occ_m1);
      hit_rank   = hit_rank | (hit_vec[i] ? rank_r[i] : '0);
      hit_val    = hit_val  | (hit_vec[i] ? vals_r[i] : '0);
      vic_key    = vic_key  | (vic_vec[i] ? keys_r[i] : '0);
    end
  end

  assign hit    = |hit_vec_r;
  assign is_put = (req_r.op == lkvc_pkg::OP_PUT);
  assign evict  = !hit && is_put && full_r && (|vic_vec_r);
  assign after  = valid_r & ~(evict ? vic_vec_r : '0);
  assign free_vec = ~after;
  assign slot_vec = (!hit && is_put) ? (free_vec & (~free_vec + N'(1))) : '0;
  assign found    = |slot_vec;

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    key_we    = '0;
    val_we    = '0;
    rsp_nxt   = '0;
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (hit) begin
      for (int i = 0; i < N; i++) begin
        if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
          rank_nxt[i] = RB'(rank_r[i] + RB'(1));
        end
        if (hit_vec_r[i]) begin
          rank_nxt[i] = '0;
        end
      end
      if (is_put) begin
        val_we = hit_vec_r;
      end
    end else if (is_put) begin
      for (int i = 0; i < N; i++) begin
        if (after[i]) begin
          rank_nxt[i] = RB'(rank_r[i] + RB'(1));
        end
        if (slot_vec[i]) begin
          rank_nxt[i] = '0;
        end
      end
      valid_nxt = after | slot_vec;
      key_we    = slot_vec;
      val_we    = slot_vec;
      occ_nxt   = OB'(occ_r - OB'(evict) + OB'(found));
    end
    rsp_nxt.hit         = hit;
    rsp_nxt.read_value  = (hit && !is_put) ? hit_val_r : '0;
    rsp_nxt.evicted     = evict;
    rsp_nxt.evicted_key = evict ? DB'(vic_key_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= lkvc_pkg::CAP_RESET;
      rsp_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      rsp_valid_r <= cmd.update;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.update) begin
        valid_r <= valid_nxt;
        occ_r   <= occ_nxt;
        for (int i = 0; i < N; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.lookup) begin
      hit_vec_r  <= hit_vec;
      vic_vec_r  <= vic_vec;
      hit_rank_r <= hit_rank;
      hit_val_r  <= hit_val;
      vic_key_r  <= vic_key;
      full_r     <= full;
    end
    if (cmd.update) begin
      rsp_r <= rsp_nxt;
      for (int i = 0; i < N; i++) begin
        if (key_we[i]) begin
          keys_r[i] <= req_key;
        end
        if (val_we[i]) begin
          vals_r[i] <= req_r.write_value;
        end
      end
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_rsp   = rsp_r;

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OB'(N))
    else $error("occupancy above entry count");
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy disagrees with valid bits");
  a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("update without response strobe");
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> ($onehot0(hit_vec_r) && $onehot0(vic_vec_r)))
    else $error("duplicate key or LRU entry");
`endif

endmodule

FILE: src/lru_key_value_cache_top.sv
// Top level: LRU key-value cache, controller plus datapath.
// Each request passes through the accept edge, a lookup cycle that
// compares the key against all entries in parallel and selects the least
// recent entry, and an update cycle that writes the entry, ranks and count.
// The response strobes on out_valid for one cycle right after the update,
// which is also the first cycle busy is low again; a new request can only
// be started while busy is low. The receiver cannot stall: out_rsp is valid
// only while out_valid is high. Write capacity only while busy is low and no
// response is pending.
module lru_key_value_cache_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lkvc_pkg::req_t                in_req,
  output logic                          out_valid,
  output lkvc_pkg::rsp_t                out_rsp,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata
);

  lkvc_pkg::ctl_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lkvc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

FILE: dv/lru_key_value_cache_top_test.sv
// Testbench for the LRU key-value cache: directed and random get/put traffic vs. an LRU predictor.
module lru_key_value_cache_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int MAX_GAP = 17;
  localparam int STALL_LIMIT = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_REQUESTS = 100;
  localparam logic [lkvc_pkg::DATA_BITS-1:0] KEY_MASK =
    (lkvc_pkg::KEY_BITS >= lkvc_pkg::DATA_BITS) ? {lkvc_pkg::DATA_BITS{1'b1}} :
    lkvc_pkg::DATA_BITS'((64'd1 << lkvc_pkg::KEY_BITS) - 64'd1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lkvc_pkg::req_t in_req = '0;
  logic out_valid;
  lkvc_pkg::rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata = '0;

  // predictor state
  logic [lkvc_pkg::DATA_BITS-1:0] line_key [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::DATA_BITS-1:0] line_val [lkvc_pkg::ENTRIES];
  bit line_valid [lkvc_pkg::ENTRIES];
  int unsigned line_rank [lkvc_pkg::ENTRIES];
  int unsigned line_count = 0;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_setting = lkvc_pkg::CAP_RESET;

  lkvc_pkg::req_t pending_reqs [$];
  lkvc_pkg::rsp_t expected_rsps [$];

  int errors = 0;
  int n_requests = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit req_taken = 1'b0;
  bit sender_idles = 1'b1;

  lru_key_value_cache_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic lkvc_pkg::rsp_t lru_access(lkvc_pkg::req_t r);
    lkvc_pkg::rsp_t rsp;
    logic [lkvc_pkg::DATA_BITS-1:0] k;
    int found;
    int victim;
    int slot;
    int unsigned lim;
    int unsigned old_rank;
    rsp = '0;
    k = r.key & KEY_MASK;
    found = -1;
    victim = -1;
    slot = -1;
    lim = (cap_setting == 0) ? 1 :
          ((cap_setting > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : cap_setting);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (line_valid[i] && line_key[i] == k) found = i;
    if (found >= 0) begin
      rsp.hit = 1'b1;
      if (r.op == lkvc_pkg::OP_PUT) line_val[found] = r.write_value;
      else rsp.read_value = line_val[found];
      old_rank = line_rank[found];
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        if (line_valid[i] && line_rank[i] < old_rank) line_rank[i]++;
      line_rank[found] = 0;
    end else if (r.op == lkvc_pkg::OP_PUT) begin
      if (line_count >= lim) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
          if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
        if (victim >= 0) begin
          rsp.evicted = 1'b1;
          rsp.evicted_key = line_key[victim];
          line_valid[victim] = 1'b0;
          if (line_count > 0) line_count--;
        end
      end
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        if (line_valid[i]) line_rank[i]++;
      for (int i = 0; i < lkvc_pkg::ENTRIES && slot < 0; i++)
        if (!line_valid[i]) slot = i;
      if (slot >= 0) begin
        line_valid[slot] = 1'b1;
        line_key[slot] = k;
        line_val[slot] = r.write_value;
        line_rank[slot] = 0;
        line_count++;
      end
    end
    return rsp;
  endfunction

  function automatic void queue_request(logic kind, logic [lkvc_pkg::DATA_BITS-1:0] k,
                                        logic [lkvc_pkg::DATA_BITS-1:0] v);
    lkvc_pkg::req_t r;
    r.op = kind;
    r.key = k;
    r.write_value = v;
    pending_reqs.push_back(r);
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_BITS-1:0] cap);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // driver: next request presented after a random gap
  always @(negedge clk) begin
    if (!start || req_taken) begin
      if (start)
        gap_left = (sender_idles && $urandom_range(0, 3) != 0) ? $urandom_range(0, MAX_GAP) : 0;
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_req <= pending_reqs.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: check responses, predict accepted requests
  always @(posedge clk) begin : monitor
    lkvc_pkg::rsp_t want;
    req_taken <= rst_n && start && !busy;
    idle_cycles <= (!rst_n || (start && !busy) || out_valid) ? 0 : idle_cycles + 1;
    if (rst_n && cfg_we) cap_setting = cfg_wdata;
    if (rst_n && out_valid) begin
      if (out_rsp.hit === 1'b1) n_hits++;
      if (out_rsp.evicted === 1'b1) n_evictions++;
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %p", $time, out_rsp);
      end else begin
        want = expected_rsps.pop_front();
        if (out_rsp.hit !== want.hit) begin
          errors++;
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_rsp.hit);
        end
        if (out_rsp.read_value !== want.read_value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   out_rsp.read_value);
        end
        if (out_rsp.evicted !== want.evicted) begin
          errors++;
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, out_rsp.evicted);
        end
        if (out_rsp.evicted_key !== want.evicted_key) begin
          errors++;
          $display("%0t: evicted_key expected %h actual %h", $time, want.evicted_key,
                   out_rsp.evicted_key);
        end
      end
    end
    if (rst_n && start && !busy) begin
      expected_rsps.push_back(lru_access(in_req));
      n_requests++;
    end
  end

  initial begin : watchdog
    do @(posedge clk);
    while (idle_cycles < STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned cap_plan [RANDOM_PHASES];
    logic [lkvc_pkg::DATA_BITS-1:0] key_pool [$];
    logic [lkvc_pkg::DATA_BITS-1:0] k;
    logic [lkvc_pkg::DATA_BITS-1:0] v;
    int unsigned pool_n;
    cap_plan = '{16, 1, 4, 31, 17, 0, 8, 2, 16, 5, 12, 3};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty cache at reset capacity
    queue_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(lkvc_pkg::OP_PUT, 32'h0000_0005, 32'h0000_0007);
    queue_request(lkvc_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);

    // capacity 2: extremes, evictions, update on hit
    write_capacity(5'd2);
    queue_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h1234_5678);
    queue_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'hAAAA_AAAA);
    queue_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h5555_5555);
    queue_request(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);

    // capacity 0 acts as 1, below current occupancy
    write_capacity(5'd0);
    queue_request(lkvc_pkg::OP_PUT, 32'h1234_5678, 32'h0000_0001);
    queue_request(lkvc_pkg::OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    queue_request(lkvc_pkg::OP_GET, 32'h1234_5678, 32'h0000_0000);
    queue_request(lkvc_pkg::OP_GET, 32'h0F0F_0F0F, 32'h0000_0000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_capacity(cap_plan[p][lkvc_pkg::CAP_BITS-1:0]);
      sender_idles = (p % 3 != 2);
      pool_n = $urandom_range(3, 30);
      key_pool.delete();
      for (int i = 0; i < pool_n; i++) key_pool.push_back($urandom);
      repeat (PHASE_REQUESTS) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
        case ($urandom_range(0, 7))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
        queue_request($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, k, v);
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Ran %0d get/put requests over %0d capacity settings (0 to 31).",
             n_requests, n_settings + 1);
    $display("Responses seen: %0d hits, %0d evictions.", n_hits, n_evictions);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
